// ===== sv/sswtm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sswtm_pkg
// Shared widths, register indexes and result codes of the substring search.
// ----------------------------------------------------------------------------
package sswtm_pkg;

  // Fixed field widths.
  localparam int unsigned TEXT_W      = 8;
  localparam int unsigned SKIP_W      = 32;
  localparam int unsigned POS_OUT_W   = 32;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned CFG_W       = 64;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 32;

  // Number of needle bytes that the two byte registers can hold.
  localparam int unsigned NEEDLE_CFG_BYTES = 16;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEEDLE_LEN = 2'd0,
    CFG_NEEDLE_LO  = 2'd1,
    CFG_NEEDLE_HI  = 2'd2
  } cfg_idx_e;

  // Result kinds as seen on the output.
  typedef enum logic [KIND_W-1:0] {
    KIND_NONE = 2'd0,
    KIND_FULL = 2'd1,
    KIND_TAIL = 2'd2
  } match_kind_e;

  // How the finishing stage has to treat a search result.
  typedef enum logic [1:0] {
    RES_EMPTY = 2'd0,
    RES_FULL  = 2'd1,
    RES_SCAN  = 2'd2
  } res_sel_e;

endpackage

// ===== sv/sswtm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sswtm_front
// Holds the needle registers, accepts text items and classifies each byte
// against every needle byte before it enters the queue.
// ----------------------------------------------------------------------------
module sswtm_front import sswtm_pkg::*; #(
  parameter int unsigned NEEDLE_MAX = 16,
  parameter int unsigned NW         = $clog2(NEEDLE_MAX + 1),
  parameter int unsigned QW         = SKIP_W + NEEDLE_MAX + 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // Incoming items
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [TEXT_W-1:0]    text_byte_i,
  input  logic                 byte_valid_i,
  input  logic                 is_last_i,
  input  logic [SKIP_W-1:0]    skip_count_i,
  // Queue write side
  output logic                 push_o,
  input  logic                 push_ready_i,
  output logic [QW-1:0]        push_data_o,
  // Effective needle length
  output logic [NW-1:0]        n_eff_o
);

  logic [LEN_W-1:0]                 len_q;
  logic [2*CFG_W-1:0]               needle_q;
  logic [NEEDLE_MAX-1:0]            eq;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      needle_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NEEDLE_LEN: len_q                   <= cfg_data_i[LEN_W-1:0];
        CFG_NEEDLE_LO:  needle_q[CFG_W-1:0]     <= cfg_data_i;
        CFG_NEEDLE_HI:  needle_q[2*CFG_W-1:CFG_W] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Needle length saturates at the number of comparators.
  always_comb begin
    if (32'(len_q) > NEEDLE_MAX) begin
      n_eff_o = NW'(NEEDLE_MAX);
    end else begin
      n_eff_o = NW'(len_q);
    end
  end

  // One comparator per needle byte; bytes past the length never match.
  for (genvar i = 0; i < NEEDLE_MAX; i++) begin : g_cmp
    if (i < NEEDLE_CFG_BYTES) begin : g_cfg
      assign eq[i] = (needle_q[8*i +: 8] == text_byte_i) && (NW'(i) < n_eff_o);
    end else begin : g_zero
      assign eq[i] = (text_byte_i == '0) && (NW'(i) < n_eff_o);
    end
  end

  // Items go straight into the queue while it has room.
  assign in_ready_o  = push_ready_i;
  assign push_o      = in_valid_i && push_ready_i;
  assign push_data_o = {skip_count_i, eq, byte_valid_i, is_last_i};

endmodule

// ===== sv/sswtm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sswtm_queue
// Two-entry queue between the classifying front and the search engine.
// ----------------------------------------------------------------------------
module sswtm_queue #(
  parameter int unsigned W = 50
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_i,
  output logic [W-1:0] pop_data_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_ptr_q;
  logic         rd_ptr_q;
  logic [1:0]   count_q;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// ===== sv/sswtm_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sswtm_engine
// Search engine: advances the bit-parallel prefix vector by one byte per cycle
// while it can pop, and hands the finishing stage a result on the last item.
// ----------------------------------------------------------------------------
module sswtm_engine import sswtm_pkg::*; #(
  parameter int unsigned NEEDLE_MAX    = 16,
  parameter int unsigned POSITION_BITS = 32,
  parameter int unsigned NW            = $clog2(NEEDLE_MAX + 1),
  parameter int unsigned QW            = SKIP_W + NEEDLE_MAX + 2,
  parameter int unsigned BW            = (POSITION_BITS > SKIP_W) ? POSITION_BITS : SKIP_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Queue read side
  input  logic                  q_valid_i,
  input  logic [QW-1:0]         q_data_i,
  output logic                  q_pop_o,
  input  logic [NW-1:0]         n_eff_i,
  // Result to the finishing stage
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output res_sel_e              res_sel_o,
  output logic [BW-1:0]         res_base_o,
  output logic [NEEDLE_MAX-1:0] res_bits_o
);

  localparam int unsigned IW = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;

  logic                     in_search_q;
  logic [NEEDLE_MAX-1:0]    prefix_q,  prefix_d;
  logic [POSITION_BITS-1:0] pos_q,     pos_d;
  logic                     full_q,    full_d;
  logic [POSITION_BITS-1:0] found_q,   found_d;
  logic [SKIP_W-1:0]        skip_q,    skip_d;

  logic [SKIP_W-1:0]        e_skip;
  logic [NEEDLE_MAX-1:0]    e_eq;
  logic                     e_valid;
  logic                     e_last;
  logic [IW-1:0]            top_idx;
  logic [POSITION_BITS-1:0] n_m1;
  logic                     at_skip;

  assign {e_skip, e_eq, e_valid, e_last} = q_data_i;

  // The last item waits until the finishing stage can take its result.
  assign q_pop_o     = q_valid_i && (!e_last || res_ready_i);
  assign res_valid_o = q_valid_i && e_last;

  assign top_idx = IW'(n_eff_i - NW'(1));
  assign n_m1    = POSITION_BITS'(n_eff_i) - POSITION_BITS'(1);

  // Per-byte update of the prefix vector and the first full match.
  always_comb begin
    if (in_search_q) begin
      prefix_d = prefix_q;
      pos_d    = pos_q;
      full_d   = full_q;
      found_d  = found_q;
      skip_d   = skip_q;
    end else begin
      prefix_d = '0;
      pos_d    = '0;
      full_d   = 1'b0;
      found_d  = '0;
      skip_d   = e_skip;
    end
    at_skip = (BW'(pos_d) >= BW'(skip_d));
    if (e_valid) begin
      prefix_d = ((prefix_d << 1) | NEEDLE_MAX'(at_skip)) & e_eq;
      if ((n_eff_i != '0) && !full_d && prefix_d[top_idx]) begin
        full_d  = 1'b1;
        found_d = (pos_d >= n_m1) ? (pos_d - n_m1) : '0;
      end
      if (pos_d != '1) begin
        pos_d = pos_d + POSITION_BITS'(1);
      end
    end
  end

  // Result selection for the finishing stage.
  always_comb begin
    res_bits_o = prefix_d;
    if (n_eff_i == '0) begin
      res_sel_o  = RES_EMPTY;
      res_base_o = BW'(skip_d);
    end else if (full_d) begin
      res_sel_o  = RES_FULL;
      res_base_o = BW'(found_d);
    end else begin
      res_sel_o  = RES_SCAN;
      res_base_o = BW'(pos_d);
    end
  end

  // Search state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_search_q <= 1'b0;
      prefix_q    <= '0;
      pos_q       <= '0;
      full_q      <= 1'b0;
      found_q     <= '0;
      skip_q      <= '0;
    end else if (q_pop_o) begin
      in_search_q <= !e_last;
      prefix_q    <= prefix_d;
      pos_q       <= pos_d;
      full_q      <= full_d;
      found_q     <= found_d;
      skip_q      <= skip_d;
    end
  end

endmodule

// ===== sv/sswtm_finish.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sswtm_finish
// Resolves a partial tail match from the final prefix vector and holds the
// result item in an output register until it is taken.
// ----------------------------------------------------------------------------
module sswtm_finish import sswtm_pkg::*; #(
  parameter int unsigned NEEDLE_MAX    = 16,
  parameter int unsigned POSITION_BITS = 32,
  parameter int unsigned NW            = $clog2(NEEDLE_MAX + 1),
  parameter int unsigned BW            = (POSITION_BITS > SKIP_W) ? POSITION_BITS : SKIP_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  res_valid_i,
  output logic                  res_ready_o,
  input  res_sel_e              res_sel_i,
  input  logic [BW-1:0]         res_base_i,
  input  logic [NEEDLE_MAX-1:0] res_bits_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [POS_OUT_W-1:0]  position_o,
  output match_kind_e           match_kind_o
);

  logic                  pend_valid_q;
  res_sel_e              pend_sel_q;
  logic [BW-1:0]         pend_base_q;
  logic [NEEDLE_MAX-1:0] pend_bits_q;

  logic                  out_valid_q;
  logic [POS_OUT_W-1:0]  out_pos_q;
  match_kind_e           out_kind_q;

  logic                  out_free;
  logic                  pend_move;
  logic [NW-1:0]         back_len;
  logic [BW-1:0]         back_ext;
  logic [BW-1:0]         pos_calc;
  match_kind_e           kind_calc;

  assign out_free    = !out_valid_q || out_ready_i;
  assign pend_move   = pend_valid_q && out_free;
  assign res_ready_o = !pend_valid_q || pend_move;

  // Length of the longest needle prefix that ends at the end of the text.
  always_comb begin
    back_len = '0;
    for (int i = 0; i < NEEDLE_MAX; i++) begin
      if (pend_bits_q[i]) begin
        back_len = NW'(i + 1);
      end
    end
  end

  assign back_ext = BW'(back_len);

  // Final position and kind.
  always_comb begin
    pos_calc  = pend_base_q;
    kind_calc = KIND_NONE;
    case (pend_sel_q)
      RES_FULL: kind_calc = KIND_FULL;
      RES_SCAN: begin
        if (back_len != '0) begin
          kind_calc = KIND_TAIL;
          pos_calc  = (pend_base_q >= back_ext) ? (pend_base_q - back_ext) : '0;
        end
      end
      default: kind_calc = KIND_NONE;
    endcase
  end

  // Pending result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (res_ready_o) begin
      pend_valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      pend_sel_q  <= res_sel_i;
      pend_base_q <= res_base_i;
      pend_bits_q <= res_bits_i;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= pend_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_move) begin
      out_pos_q  <= pos_calc[POS_OUT_W-1:0];
      out_kind_q <= kind_calc;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign position_o   = out_pos_q;
  assign match_kind_o = out_kind_q;

endmodule

// ===== sv/substring_search_with_tail_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_search_with_tail_match
// Streaming first-occurrence substring search with partial tail match.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Contents
//  s_axis   | in        | tdata: text_byte, skip_count; tuser: byte_valid;
//           |           | tlast: is_last
//  m_axis   | out       | tdata: position; tuser: match_kind
//  cfg      | in        | needle_length, needle_bytes_low, needle_bytes_high
//
// One text item is taken every cycle while the queue has room; the search
// engine updates the prefix vector by one byte per cycle while it can pop.
// A result passes through the queue, pending stage and output register.
// Reset clears all control state and the needle registers at once.
// Output stalls back up through the pending stage into the two-entry queue,
// and the input side stalls only once the queue is full behind a last item.
// ----------------------------------------------------------------------------
module substring_search_with_tail_match import sswtm_pkg::*; #(
  parameter int unsigned NEEDLE_MAX    = 16,
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  // Text input
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // text_byte[7:0], skip_count[39:8]
  input  logic [0:0]             s_axis_tuser,  // byte_valid[0]
  input  logic                   s_axis_tlast,
  // Result output
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // position[31:0]
  output logic [KIND_W-1:0]      m_axis_tuser   // match_kind[1:0]
);

  localparam int unsigned NW = $clog2(NEEDLE_MAX + 1);
  localparam int unsigned QW = SKIP_W + NEEDLE_MAX + 2;
  localparam int unsigned BW = (POSITION_BITS > SKIP_W) ? POSITION_BITS : SKIP_W;

  logic                  push;
  logic                  push_ready;
  logic [QW-1:0]         push_data;
  logic                  q_valid;
  logic                  q_pop;
  logic [QW-1:0]         q_data;
  logic [NW-1:0]         n_eff;
  logic                  res_valid;
  logic                  res_ready;
  res_sel_e              res_sel;
  logic [BW-1:0]         res_base;
  logic [NEEDLE_MAX-1:0] res_bits;
  match_kind_e           match_kind;

  // Front: needle registers and byte classification.
  sswtm_front #(
    .NEEDLE_MAX (NEEDLE_MAX),
    .NW         (NW),
    .QW         (QW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .text_byte_i  (s_axis_tdata[TEXT_W-1:0]),
    .byte_valid_i (s_axis_tuser[0]),
    .is_last_i    (s_axis_tlast),
    .skip_count_i (s_axis_tdata[TEXT_W +: SKIP_W]),
    .push_o       (push),
    .push_ready_i (push_ready),
    .push_data_o  (push_data),
    .n_eff_o      (n_eff)
  );

  // Queue between front and engine.
  sswtm_queue #(
    .W (QW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_data_o   (q_data)
  );

  // Back: search engine.
  sswtm_engine #(
    .NEEDLE_MAX    (NEEDLE_MAX),
    .POSITION_BITS (POSITION_BITS),
    .NW            (NW),
    .QW            (QW),
    .BW            (BW)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .n_eff_i     (n_eff),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_sel_o   (res_sel),
    .res_base_o  (res_base),
    .res_bits_o  (res_bits)
  );

  // Tail-match resolution and output register.
  sswtm_finish #(
    .NEEDLE_MAX    (NEEDLE_MAX),
    .POSITION_BITS (POSITION_BITS),
    .NW            (NW),
    .BW            (BW)
  ) u_finish (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_valid_i  (res_valid),
    .res_ready_o  (res_ready),
    .res_sel_i    (res_sel),
    .res_base_i   (res_base),
    .res_bits_i   (res_bits),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .position_o   (m_axis_tdata),
    .match_kind_o (match_kind)
  );

  assign m_axis_tuser = match_kind;

endmodule

// ===== sv/sswtm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sswtm_checker
// Port-level checks of the substring search, bound to the top level.
// ----------------------------------------------------------------------------
module sswtm_checker import sswtm_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   s_axis_tlast,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [KIND_W-1:0]      m_axis_tuser
);

  logic [2:0] open_q;
  logic       last_in;
  logic       res_out;

  assign last_in = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  assign res_out = m_axis_tvalid && m_axis_tready;

  // Searches ended at the input whose result has not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (last_in && !res_out) begin
      open_q <= open_q + 3'd1;
    end else if (res_out && !last_in) begin
      open_q <= open_q - 3'd1;
    end
  end

  // A stalled result item holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result item changed while stalled");

  // Every result item belongs to a search that has ended.
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> open_q != 3'd0)
    else $error("result item without an ended search");

  // The input stalls only behind an ended search whose result is pending.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> open_q != 3'd0)
    else $error("input stalled with no result pending");

  // The queue, pending stage and output register bound the backlog.
  a_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= 3'd4)
    else $error("too many results in flight");

  // The match kind never takes the unused code.
  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == KIND_NONE || m_axis_tuser == KIND_FULL ||
                       m_axis_tuser == KIND_TAIL))
    else $error("illegal match kind");

endmodule

bind substring_search_with_tail_match sswtm_checker u_checker (.*);
